/* rtl/ccm_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the contact cache merge unit
// used by ccm_area and contact_cache_merge_unit
package ccm_pkg;

  localparam int SLOTS      = 4;
  localparam int SLOT_W     = 2;
  localparam int FILL_W     = 3;
  localparam int POS_W      = 32;
  localparam int NRM_W      = 18;
  localparam int AREA_W     = 136;
  localparam int THR_W      = 31;
  localparam int LIM_W      = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 31;

  localparam logic [THR_W-1:0] THR_RESET = 31'd655;
  localparam logic [LIM_W-1:0] LIM_RESET = 17'd64881;

  localparam logic CMD_MERGE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOT_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ACT_MATCH   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] az;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic signed [POS_W-1:0] bz;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic signed [POS_W-1:0] depth;
  } slot_row_t;

  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    logic              zero;
  } area_tag_t;

  // slots spanning the area for each replacement candidate
  function automatic logic [SLOT_W-1:0] area_pt(input logic [SLOT_W-1:0] cand,
                                                input logic [1:0] part);
    logic [3*SLOT_W-1:0] pts;
    logic [SLOT_W-1:0]   res;
    unique case (cand)
      2'd0:    pts = {2'd1, 2'd3, 2'd2};
      2'd1:    pts = {2'd0, 2'd3, 2'd2};
      2'd2:    pts = {2'd0, 2'd3, 2'd1};
      default: pts = {2'd0, 2'd2, 2'd1};
    endcase
    case (part)
      2'd0:    res = pts[5:4];
      2'd1:    res = pts[3:2];
      default: res = pts[1:0];
    endcase
    return res;
  endfunction

endpackage

/* rtl/ccm_area.sv */
`timescale 1ns / 1ps
// pipelined exact squared cross-product area, one candidate per cycle, seven stages
// depends on ccm_pkg
module ccm_area (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_v,
  input  ccm_pkg::area_tag_t         in_tag,
  input  ccm_pkg::vec3_t             a_new,
  input  ccm_pkg::vec3_t             a_p,
  input  ccm_pkg::vec3_t             a_q,
  input  ccm_pkg::vec3_t             a_r,
  output logic                       out_v,
  output ccm_pkg::area_tag_t         out_tag,
  output logic [ccm_pkg::AREA_W-1:0] area
);

  logic [6:0]          stg_v;
  ccm_pkg::area_tag_t  tag [7];

  logic signed [32:0]  u [3];
  logic signed [32:0]  w [3];
  logic signed [65:0]  pa [3];
  logic signed [65:0]  pb [3];
  logic signed [66:0]  c [3];
  logic [66:0]         mag [3];
  logic [65:0]         hh [3];
  logic [66:0]         hl [3];
  logic [67:0]         ll [3];
  logic [ccm_pkg::AREA_W-1:0] sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_v <= '0;
    end else begin
      stg_v <= {stg_v[5:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    tag[0] <= in_tag;
    for (int i = 1; i < 7; i++) begin
      tag[i] <= tag[i-1];
    end
    // point differences
    u[0] <= 33'(a_new.x) - 33'(a_p.x);
    u[1] <= 33'(a_new.y) - 33'(a_p.y);
    u[2] <= 33'(a_new.z) - 33'(a_p.z);
    w[0] <= 33'(a_q.x) - 33'(a_r.x);
    w[1] <= 33'(a_q.y) - 33'(a_r.y);
    w[2] <= 33'(a_q.z) - 33'(a_r.z);
    // cross product terms
    pa[0] <= u[1] * w[2];
    pb[0] <= u[2] * w[1];
    pa[1] <= u[2] * w[0];
    pb[1] <= u[0] * w[2];
    pa[2] <= u[0] * w[1];
    pb[2] <= u[1] * w[0];
    for (int k = 0; k < 3; k++) begin
      c[k]   <= 67'(pa[k]) - 67'(pb[k]);
      mag[k] <= c[k][66] ? 67'(-c[k]) : 67'(c[k]);
      // square split into partial products
      hh[k]  <= mag[k][66:34] * mag[k][66:34];
      hl[k]  <= mag[k][66:34] * mag[k][33:0];
      ll[k]  <= mag[k][33:0] * mag[k][33:0];
      sq[k]  <= ccm_pkg::AREA_W'({hh[k], 68'd0}) + ccm_pkg::AREA_W'({hl[k], 35'd0})
              + ccm_pkg::AREA_W'(ll[k]);
    end
    area <= tag[5].zero ? '0 : (sq[0] + sq[1] + sq[2]);
  end

  assign out_v   = stg_v[6];
  assign out_tag = tag[6];

endmodule

/* rtl/contact_cache_merge_unit.sv */
`timescale 1ns / 1ps
// contact cache merge unit: four-slot contact cache for one body pair
// depends on ccm_pkg and ccm_area
//
// One item at a time. The four slots live in a synchronous memory with a
// registered read. A clear goes from acceptance straight to the done state,
// which loads the output register, and the unit then returns to idle for the
// next item. A merge reads the four slots one per cycle through a three-stage
// match test and returns its word when a slot matches or a slot is free. With
// a full cache and no match, twelve more reads fetch the three corner points
// of each of the four replacement candidates and a seven-stage area pipeline
// ranks them before the word is returned. The result sits in an output
// register, so the next item is taken while it waits; a second result behind
// it stalls the input until the first is taken.
module contact_cache_merge_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                command,
  input  logic signed [31:0]                  local_a_x,
  input  logic signed [31:0]                  local_a_y,
  input  logic signed [31:0]                  local_a_z,
  input  logic signed [31:0]                  local_b_x,
  input  logic signed [31:0]                  local_b_y,
  input  logic signed [31:0]                  local_b_z,
  input  logic signed [17:0]                  normal_x,
  input  logic signed [17:0]                  normal_y,
  input  logic signed [17:0]                  normal_z,
  input  logic signed [31:0]                  depth,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [1:0]                          action,
  output logic [1:0]                          slot,
  output logic [2:0]                          fill,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ccm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ccm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DIST_W  = 58;
  localparam int TCMP_W  = ccm_pkg::THR_W + FRAC_BITS;
  localparam int CMP_W   = (TCMP_W > DIST_W) ? TCMP_W : DIST_W;
  localparam int DSUM_W  = 38;
  localparam int LCMP_W  = ccm_pkg::LIM_W + FRAC_BITS + 1;
  localparam int DOT_W   = (LCMP_W > DSUM_W) ? LCMP_W : DSUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_AREA = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  logic [ccm_pkg::THR_W-1:0]  thr;
  logic [ccm_pkg::LIM_W-1:0]  lim;
  logic [ccm_pkg::FILL_W-1:0] fill_count;

  ccm_pkg::slot_row_t in_row;
  ccm_pkg::slot_row_t rd_row;
  ccm_pkg::slot_row_t mem [ccm_pkg::SLOTS];
  logic [ccm_pkg::SLOT_W-1:0] mem_ra;
  logic                       mem_we;

  // scan
  logic [2:0]                 iss;
  logic                       rd_v;
  logic [ccm_pkg::SLOT_W-1:0] rd_idx;
  logic                       m1_v;
  logic [ccm_pkg::SLOT_W-1:0] m1_idx;
  logic [27:0]                m1_mag [3];
  logic                       m1_far;
  logic signed [17:0]         m1_n [3];
  logic                       m2_v;
  logic [ccm_pkg::SLOT_W-1:0] m2_idx;
  logic [55:0]                m2_sq [3];
  logic signed [35:0]         m2_dp [3];
  logic                       m2_far;
  logic                       sdone;
  logic                       hit;
  logic [ccm_pkg::SLOT_W-1:0] hit_slot;
  logic                       prot_v;
  logic [ccm_pkg::SLOT_W-1:0] prot;
  logic signed [31:0]         deepest;

  logic signed [32:0]         dx, dy, dz;
  logic [32:0]                adx, ady, adz;
  logic [DIST_W-1:0]          sq_dist;
  logic signed [DSUM_W-1:0]   dot;
  logic [CMP_W-1:0]           thr_cmp;
  logic signed [DOT_W-1:0]    lim_cmp;
  logic signed [DOT_W-1:0]    dot_cmp;
  logic                       match;

  // replacement
  logic [2:0]                 cand;
  logic [1:0]                 part;
  logic                       ar_v;
  logic [1:0]                 ar_part;
  logic [ccm_pkg::SLOT_W-1:0] ar_cand;
  ccm_pkg::vec3_t             pos_p, pos_q, row_a, new_a;
  ccm_pkg::area_tag_t         a_in_tag, a_out_tag;
  logic                       a_in_v, a_out_v, take;
  logic [ccm_pkg::AREA_W-1:0] a_sum, best;
  logic [ccm_pkg::SLOT_W-1:0] best_slot;

  // result
  ccm_pkg::action_t           res_action;
  logic [ccm_pkg::SLOT_W-1:0] res_slot;
  logic [ccm_pkg::FILL_W-1:0] res_fill;
  logic                       done_fire;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign done_fire  = (state == S_DONE) && (!result_valid || result_ready);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ccm_pkg::THR_RESET;
      lim <= ccm_pkg::LIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ccm_pkg::CFG_THRESHOLD: thr <= cfg_data;
        ccm_pkg::CFG_DOT_LIMIT: lim <= cfg_data[ccm_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // slot memory
  assign mem_ra = (state == S_AREA) ? ccm_pkg::area_pt(cand[1:0], part) : iss[1:0];
  assign mem_we = done_fire && (res_action != ccm_pkg::ACT_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[res_slot] <= in_row;
    end
    rd_row <= mem[mem_ra];
  end

  // match test
  assign dx  = 33'(in_row.ax) - 33'(rd_row.ax);
  assign dy  = 33'(in_row.ay) - 33'(rd_row.ay);
  assign dz  = 33'(in_row.az) - 33'(rd_row.az);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign adz = dz[32] ? 33'(-dz) : 33'(dz);

  assign sq_dist = DIST_W'(m2_sq[0]) + DIST_W'(m2_sq[1]) + DIST_W'(m2_sq[2]);
  assign dot     = DSUM_W'(m2_dp[0]) + DSUM_W'(m2_dp[1]) + DSUM_W'(m2_dp[2]);
  assign thr_cmp = CMP_W'(thr) << FRAC_BITS;
  assign lim_cmp = DOT_W'(lim) << FRAC_BITS;
  assign dot_cmp = DOT_W'(dot);
  assign match   = !m2_far && (CMP_W'(sq_dist) < thr_cmp) && (dot_cmp > lim_cmp)
                   && ({1'b0, m2_idx} < fill_count);

  always_ff @(posedge clk) begin
    m1_idx    <= rd_idx;
    m1_mag[0] <= adx[27:0];
    m1_mag[1] <= ady[27:0];
    m1_mag[2] <= adz[27:0];
    m1_far    <= (|adx[32:28]) || (|ady[32:28]) || (|adz[32:28]);
    m1_n[0]   <= rd_row.nx;
    m1_n[1]   <= rd_row.ny;
    m1_n[2]   <= rd_row.nz;
    m2_idx    <= m1_idx;
    m2_far    <= m1_far;
    m2_dp[0]  <= in_row.nx * m1_n[0];
    m2_dp[1]  <= in_row.ny * m1_n[1];
    m2_dp[2]  <= in_row.nz * m1_n[2];
    for (int k = 0; k < 3; k++) begin
      m2_sq[k] <= m1_mag[k] * m1_mag[k];
    end
  end

  // area operands
  assign row_a     = '{x: rd_row.ax, y: rd_row.ay, z: rd_row.az};
  assign new_a     = '{x: in_row.ax, y: in_row.ay, z: in_row.az};
  assign a_in_v    = ar_v && (ar_part == 2'd2);
  assign a_in_tag  = '{idx: ar_cand, zero: prot_v && (prot == ar_cand)};
  assign take      = (a_out_tag.idx == '0) || (a_sum > best);

  always_ff @(posedge clk) begin
    if (ar_v && ar_part == 2'd0) begin
      pos_p <= row_a;
    end
    if (ar_v && ar_part == 2'd1) begin
      pos_q <= row_a;
    end
  end

  ccm_area u_area (
    .clk     (clk),
    .rst     (rst),
    .in_v    (a_in_v),
    .in_tag  (a_in_tag),
    .a_new   (new_a),
    .a_p     (pos_p),
    .a_q     (pos_q),
    .a_r     (row_a),
    .out_v   (a_out_v),
    .out_tag (a_out_tag),
    .area    (a_sum)
  );

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      m1_v  <= 1'b0;
      m2_v  <= 1'b0;
      sdone <= 1'b0;
      ar_v  <= 1'b0;
    end else begin
      rd_v  <= (state == S_SCAN) && !iss[2];
      m1_v  <= rd_v;
      m2_v  <= m1_v;
      sdone <= m2_v && (m2_idx == 2'd3);
      ar_v  <= (state == S_AREA) && !cand[2];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_count   <= '0;
      result_valid <= 1'b0;
      hit          <= 1'b0;
      prot_v       <= 1'b0;
      iss          <= '0;
      cand         <= '0;
      part         <= '0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (m2_v && match) begin
        hit <= 1'b1;
      end
      if (rd_v && (rd_row.depth < deepest)) begin
        prot_v <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            hit    <= 1'b0;
            prot_v <= 1'b0;
            iss    <= '0;
            cand   <= '0;
            part   <= '0;
            state  <= (command == ccm_pkg::CMD_CLEAR) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (!iss[2]) begin
            iss <= iss + 3'd1;
          end
          if (sdone && !hit && fill_count[2]) begin
            state <= S_AREA;
          end else if (sdone) begin
            state <= S_DONE;
          end
        end
        S_AREA: begin
          if (!cand[2]) begin
            if (part == 2'd2) begin
              part <= '0;
              cand <= cand + 3'd1;
            end else begin
              part <= part + 2'd1;
            end
          end
          if (a_out_v && a_out_tag.idx == 2'd3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            result_valid <= 1'b1;
            fill_count   <= res_fill;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item, result and bookkeeping payload
  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_row.ax    <= local_a_x;
      in_row.ay    <= local_a_y;
      in_row.az    <= local_a_z;
      in_row.bx    <= local_b_x;
      in_row.by    <= local_b_y;
      in_row.bz    <= local_b_z;
      in_row.nx    <= normal_x;
      in_row.ny    <= normal_y;
      in_row.nz    <= normal_z;
      in_row.depth <= depth;
      deepest      <= depth;
      res_action   <= ccm_pkg::ACT_CLEAR;
      res_slot     <= '0;
      res_fill     <= '0;
    end
    if (m2_v && match) begin
      hit_slot <= m2_idx;
    end
    if (rd_v && (rd_row.depth < deepest)) begin
      prot    <= rd_idx;
      deepest <= rd_row.depth;
    end
    rd_idx  <= iss[1:0];
    ar_part <= part;
    ar_cand <= cand[1:0];
    if (state == S_SCAN && sdone) begin
      if (hit) begin
        res_action <= ccm_pkg::ACT_MATCH;
        res_slot   <= hit_slot;
        res_fill   <= fill_count;
      end else if (!fill_count[2]) begin
        res_action <= ccm_pkg::ACT_APPEND;
        res_slot   <= fill_count[ccm_pkg::SLOT_W-1:0];
        res_fill   <= fill_count + 3'd1;
      end
    end
    if (a_out_v && take) begin
      best      <= a_sum;
      best_slot <= a_out_tag.idx;
    end
    if (state == S_AREA && a_out_v && a_out_tag.idx == 2'd3) begin
      res_action <= ccm_pkg::ACT_REPLACE;
      res_slot   <= take ? a_out_tag.idx : best_slot;
      res_fill   <= fill_count;
    end
    if (done_fire) begin
      action <= res_action;
      slot   <= res_slot;
      fill   <= res_fill;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 3'(ccm_pkg::SLOTS))
    else $error("fill count above slot count");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (done_fire && res_action == ccm_pkg::ACT_APPEND) |=> fill_count == $past(fill_count) + 3'd1)
    else $error("append did not grow the fill count");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !(rd_v || m1_v || m2_v || ar_v || a_out_v))
    else $error("pipeline busy while taking a new word");

endmodule
